### rtl/sha_pkg.sv
// SHA-256 stream hasher: shared types, constants and the round constant table.
// Used by sha_round_unit and sha256_stream_hasher; depends on nothing else.
`timescale 1ns / 1ps

package sha_pkg;

   localparam int WORD_BITS  = 32;
   localparam int HASH_WORDS = 8;
   localparam int SCHED_WORDS = 16;
   localparam int BLOCK_BITS = WORD_BITS * SCHED_WORDS;
   localparam int ROUNDS     = 64;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LENGTH_POS = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef word_type hash_type [HASH_WORDS];

   // Commands from the byte sequencer to the round unit.
   typedef struct packed {
      logic start;     // load a block and run the rounds
      logic restart;   // reload the initial hash values
   } core_ctl_type;

   typedef struct packed {
      logic done;      // final add happens at this edge
   } core_stat_type;

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type v;
      unique case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         3'd7: v = 32'h5be0cd19;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type v;
      unique case (idx)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/sha_round_unit.sv
// SHA-256 compression: one round per cycle on a shared round datapath,
// rolling 16-word message schedule and the chaining hash. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_round_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sha_pkg::core_ctl_type                ctl,
   input  logic [sha_pkg::BLOCK_BITS-1:0]       block,
   output sha_pkg::core_stat_type               stat,
   output sha_pkg::hash_type                    hash
);

   function automatic sha_pkg::word_type rotr(input sha_pkg::word_type v, input int n);
      return sha_pkg::word_type'({v, v} >> n);
   endfunction

   sha_pkg::hash_type hash_ff, hash_in;
   sha_pkg::hash_type work_ff, work_in;
   sha_pkg::word_type sched_ff [sha_pkg::SCHED_WORDS];
   sha_pkg::word_type sched_in [sha_pkg::SCHED_WORDS];
   logic [5:0] rnd_ff, rnd_in;
   logic       run_ff, run_in;
   logic       fin_ff, fin_in;

   sha_pkg::word_type big_s0, big_s1, ch, maj, t1, t2, sig0, sig1, w_new;

   always_comb begin
      big_s1 = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      ch     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1     = work_ff[7] + big_s1 + ch + sha_pkg::round_k(rnd_ff) + sched_ff[0];
      big_s0 = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      maj    = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
             ^ (work_ff[1] & work_ff[2]);
      t2     = big_s0 + maj;
      sig0   = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      sig1   = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      w_new  = sched_ff[0] + sig0 + sched_ff[9] + sig1;
   end

   always_comb begin
      hash_in  = hash_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      rnd_in   = rnd_ff;
      run_in   = run_ff;
      fin_in   = fin_ff;
      priority if (ctl.restart) begin
         for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
            hash_in[i] = sha_pkg::init_hash(3'(i));
         end
      end else if (ctl.start) begin
         for (int i = 0; i < sha_pkg::SCHED_WORDS; i++) begin
            sched_in[i] = block[sha_pkg::BLOCK_BITS-1 - sha_pkg::WORD_BITS*i -: sha_pkg::WORD_BITS];
         end
         work_in = hash_ff;
         rnd_in  = '0;
         run_in  = 1'b1;
         fin_in  = 1'b0;
      end else if (fin_ff) begin
         // fold the working variables back into the chaining hash
         for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
         run_in = 1'b0;
         fin_in = 1'b0;
      end else if (run_ff) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
         for (int i = 0; i < sha_pkg::SCHED_WORDS - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[sha_pkg::SCHED_WORDS-1] = w_new;
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'(sha_pkg::ROUNDS - 1)) begin
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
            hash_ff[i] <= sha_pkg::init_hash(3'(i));
         end
         rnd_ff <= '0;
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         rnd_ff  <= rnd_in;
         run_ff  <= run_in;
         fin_ff  <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign stat.done = fin_ff;
   assign hash      = hash_ff;

endmodule

### rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte packing, padding sequencer, digest output.
// Depends on sha_pkg and sha_round_unit.
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  req_    | in        | req_valid / req_ready | data_byte, byte_present, end_of_message
//  rsp_    | out       | rsp_valid / rsp_ready | digest_part, digest_word, digest_last
//
// Each item with a byte is packed into the block; the 64th byte of a block also starts the
// shared round unit: 64 rounds, then a final add, while req_ready stays low.
// An end item then runs the padding sequencer at one pad byte per cycle while no compression
// runs (up to 72 bytes, with one or two more compressions), then offers four digest items.
// req_ready is high only while the sequencer is idle; the digest items wait on rsp_ready.
// Reset is synchronous and active high and restores the initial hash and an empty message.

module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_digest_part,
   output logic [63:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,   // take message items
      ST_COMP = 4'b0010,   // round unit busy on a full block
      ST_PAD  = 4'b0100,   // feed 0x80, zeros and the bit length
      ST_OUT  = 4'b1000    // offer the four digest items
   } state_type;

   state_type state_ff, state_in;
   state_type after_ff, after_in;   // where to go once a compression finishes

   logic [sha_pkg::BLOCK_BITS-1:0] blk_ff, blk_in;   // byte shift line, first byte on top
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        mark_ff, mark_in;    // pad mark already placed
   logic [2:0]  len_ff, len_in;      // next length byte, most significant first
   logic [1:0]  part_ff, part_in;

   logic        put_en;
   logic [7:0]  put_byte;
   logic        len_phase;
   logic [7:0]  len_byte;

   sha_pkg::core_ctl_type  core_ctl;
   sha_pkg::core_stat_type core_stat;
   sha_pkg::hash_type      hash;

   // length byte i sits at bit 8*(7-i) of the bit count
   assign len_phase = (len_ff != 3'd0) || (fill_ff == sha_pkg::LENGTH_POS);
   assign len_byte  = 8'(bits_ff >> {~len_ff, 3'b000});

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      mark_in  = mark_ff;
      len_in   = len_ff;
      part_in  = part_ff;
      put_en   = 1'b0;
      put_byte = '0;
      core_ctl = '0;

      unique case (state_ff)
         ST_IDLE: begin
            mark_in = 1'b0;
            len_in  = '0;
            part_in = '0;
            if (req_valid) begin
               if (req_byte_present) begin
                  put_en   = 1'b1;
                  put_byte = req_data_byte;
                  bits_in  = bits_ff + 64'd8;
               end
               // a full block goes to the round unit before padding starts
               if (req_byte_present && (fill_ff == sha_pkg::LAST_POS)) begin
                  state_in = ST_COMP;
                  after_in = req_end_of_message ? ST_PAD : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            put_en = 1'b1;
            if (!mark_ff) begin
               put_byte = sha_pkg::PAD_MARK;
               mark_in  = 1'b1;
            end else if (len_phase) begin
               put_byte = len_byte;
               len_in   = len_ff + 3'd1;
            end
            if (fill_ff == sha_pkg::LAST_POS) begin
               state_in = ST_COMP;
               after_in = (mark_ff && len_phase && (len_ff == 3'd7)) ? ST_OUT : ST_PAD;
            end
         end
         ST_COMP: begin
            if (core_stat.done) begin
               state_in = after_ff;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  // digest delivered: start the next message from scratch
                  state_in         = ST_IDLE;
                  core_ctl.restart = 1'b1;
                  bits_in          = '0;
                  fill_in          = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (put_en) begin
         blk_in  = {blk_ff[sha_pkg::BLOCK_BITS-9:0], put_byte};
         fill_in = fill_ff + 6'd1;
      end
      core_ctl.start = put_en && (fill_ff == sha_pkg::LAST_POS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         mark_ff  <= 1'b0;
         len_ff   <= '0;
         part_ff  <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         mark_ff  <= mark_in;
         len_ff   <= len_in;
         part_ff  <= part_in;
      end
   end

   // payload only: no reset
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   // the round unit loads the block as it completes, so it sees blk_in
   sha_round_unit u_round (
      .clock (clock),
      .reset (reset),
      .ctl   (core_ctl),
      .block (blk_in),
      .stat  (core_stat),
      .hash  (hash)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_part = part_ff;
   assign rsp_digest_last = (part_ff == 2'd3);

   always_comb begin
      unique case (part_ff)
         2'd0:    rsp_digest_word = {hash[0], hash[1]};
         2'd1:    rsp_digest_word = {hash[2], hash[3]};
         2'd2:    rsp_digest_word = {hash[4], hash[5]};
         default: rsp_digest_word = {hash[6], hash[7]};
      endcase
   end

endmodule
